FILE: hdl/tcle_pkg.sv
// shared types and constants of the text console line editor
package tcle_pkg;

    localparam int COL_W  = 10;
    localparam int CELL_W = 7;

    localparam logic [COL_W-1:0] ROW_MAX = 10'd1023;

    // item opcodes
    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_KEY   = 1'b1;

    // result kinds
    localparam logic KIND_GLYPH = 1'b0;
    localparam logic KIND_LINE  = 1'b1;

    // character codes
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    // configuration register indexes
    localparam logic [2:0] CFG_COLUMNS     = 3'd0;
    localparam logic [2:0] CFG_CELL_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_CELL_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_FOREGROUND  = 3'd3;
    localparam logic [2:0] CFG_BACKGROUND  = 3'd4;

    // configuration reset values
    localparam logic [COL_W-1:0]  RST_COLUMNS     = 10'd80;
    localparam logic [CELL_W-1:0] RST_CELL_WIDTH  = 7'd8;
    localparam logic [CELL_W-1:0] RST_CELL_HEIGHT = 7'd16;
    localparam logic [31:0]       RST_FOREGROUND  = 32'hFFFF_FFFF;
    localparam logic [31:0]       RST_BACKGROUND  = 32'hFF00_0000;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [7:0]  byte_value;
        logic [31:0] fg_out;
        logic [31:0] bg_out;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  columns;
        logic [CELL_W-1:0] cell_width;
        logic [CELL_W-1:0] cell_height;
        logic [31:0]       foreground;
        logic [31:0]       background;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_PRINT = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_KEY   = 2'd2
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t  code;
        logic [7:0] ch;
    } cmd_item_t;

endpackage

FILE: hdl/tcle_ram.sv
// generic single write port ram with registered read
module tcle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tcle_fifo.sv
// small register queue with full and empty flags
module tcle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

FILE: hdl/tcle_front.sv
// input side: accepts items, classifies them and queues commands
module tcle_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tcle_pkg::in_item_t   item,
    output logic                 full,
    input  logic                 cmd_pop,
    output tcle_pkg::cmd_item_t  cmd_item,
    output logic                 cmd_empty
);

    import tcle_pkg::*;

    cmd_item_t                  cls;
    logic [$bits(cmd_item_t)-1:0] cmd_bits;

    // key cr turns into newline, key del becomes an erase
    always_comb
    begin
        cls.ch = item.char_code;
        if (item.opcode == OP_PRINT)
        begin
            cls.code = CMD_PRINT;
        end
        else if (item.char_code == CH_DEL)
        begin
            cls.code = CMD_ERASE;
        end
        else
        begin
            cls.code = CMD_KEY;
            if (item.char_code == CH_CR)
            begin
                cls.ch = CH_NL;
            end
        end
    end

    tcle_fifo #(
        .WIDTH ($bits(cmd_item_t)),
        .DEPTH (2)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (cls),
        .full  (full),
        .pop   (cmd_pop),
        .dout  (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd_item = cmd_item_t'(cmd_bits);

endmodule

FILE: hdl/tcle_back.sv
// execution side: cursor, glyph commands, line store and line flush
module tcle_back #(
    parameter int LINE_DEPTH = 32,
    parameter int TAB_STOP   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tcle_pkg::cfg_t       cfg,
    input  tcle_pkg::cmd_item_t  cmd_item,
    input  logic                 cmd_empty,
    output logic                 cmd_pop,
    output logic                 out_push,
    output tcle_pkg::out_item_t  out_item,
    input  logic                 out_full
);

    import tcle_pkg::*;

    localparam int CNT_W    = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W   = $clog2(LINE_DEPTH);
    localparam int RW       = $clog2(TAB_STOP) + 1;
    localparam int X_W      = COL_W + 1;
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int RECIP    = ((1 << RECIP_SH) + TAB_STOP - 1) / TAB_STOP;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MOD  = 7'b0000010,
        ST_EXEC = 7'b0000100,
        ST_DRAW = 7'b0001000,
        ST_RD   = 7'b0010000,
        ST_WR   = 7'b0100000,
        ST_NL   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    cmd_code_t         code_reg, code_next;
    logic [7:0]        ch_reg, ch_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [COL_W-1:0]  dcol_reg, dcol_next;
    logic [COL_W-1:0]  drow_reg, drow_next;

    logic [COL_W-1:0]  cols;
    logic [X_W-1:0]    cols_x;
    logic [X_W-1:0]    x_pre;
    logic [COL_W-1:0]  row_mid;
    logic [COL_W-1:0]  x_fin;
    logic [COL_W-1:0]  row_fin;
    logic              draw;
    logic [COL_W-1:0]  dcol;
    logic [COL_W+RECIP_W-1:0] quo_full;
    logic [COL_W-1:0]  quo;
    logic [COL_W-1:0]  rem_full;
    logic [COL_W+CELL_W-1:0] px_full;
    logic [COL_W+CELL_W-1:0] py_full;

    logic              ram_we;
    logic [7:0]        ram_rdata;

    tcle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ch_reg),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign cols   = (cfg.columns == '0) ? COL_W'(1) : cfg.columns;
    assign cols_x = {1'b0, cols};

    // column mod tab stop by reciprocal multiply, exact for every 10 bit column
    assign quo_full = col_reg * (COL_W+RECIP_W)'(RECIP);
    assign quo      = quo_full[RECIP_SH +: COL_W];
    assign rem_full = col_reg - quo * COL_W'(TAB_STOP);

    assign px_full = dcol_reg * cfg.cell_width;
    assign py_full = drow_reg * cfg.cell_height;

    // cursor move for one console byte
    always_comb
    begin
        x_pre   = {1'b0, col_reg};
        row_mid = row_reg;
        draw    = 1'b0;
        dcol    = col_reg;
        case (ch_reg)
            CH_NL:
            begin
                x_pre = cols_x;
            end
            CH_CR:
            begin
                x_pre = '0;
            end
            CH_TAB:
            begin
                x_pre = {1'b0, col_reg} + X_W'(TAB_STOP) - X_W'(rem_reg);
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    x_pre = {1'b0, col_reg} - X_W'(1);
                    dcol  = col_reg - COL_W'(1);
                    draw  = 1'b1;
                end
                else if (row_reg != '0)
                begin
                    row_mid = row_reg - COL_W'(1);
                    x_pre   = cols_x - X_W'(1);
                    dcol    = cols - COL_W'(1);
                    draw    = 1'b1;
                end
            end
            default:
            begin
                x_pre = {1'b0, col_reg} + X_W'(1);
                draw  = 1'b1;
            end
        endcase
        if (x_pre >= cols_x)
        begin
            x_fin   = '0;
            row_fin = (row_mid < ROW_MAX) ? row_mid + COL_W'(1) : row_mid;
        end
        else
        begin
            x_fin   = x_pre[COL_W-1:0];
            row_fin = row_mid;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        code_next  = code_reg;
        ch_next    = ch_reg;
        rem_next   = rem_reg;
        dcol_next  = dcol_reg;
        drow_next  = drow_reg;
        cmd_pop    = 1'b0;
        out_push   = 1'b0;
        out_item   = '0;
        ram_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop   = 1'b1;
                    code_next = cmd_item.code;
                    ch_next   = cmd_item.ch;
                    rem_next  = '0;
                    if (cmd_item.code == CMD_ERASE)
                    begin
                        // erase on an empty line does nothing
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                            ch_next    = CH_BS;
                            state_next = ST_EXEC;
                        end
                    end
                    else if (cmd_item.ch == CH_TAB)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_MOD:
            begin
                rem_next   = rem_full[RW-1:0];
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                col_next  = x_fin;
                row_next  = row_fin;
                dcol_next = dcol;
                drow_next = row_mid;
                idx_next  = '0;
                if (code_reg == CMD_KEY && ch_reg != CH_NL && count_reg < CNT_W'(LINE_DEPTH))
                begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
                if (draw)
                begin
                    state_next = ST_DRAW;
                end
                else if (code_reg == CMD_KEY && ch_reg == CH_NL)
                begin
                    state_next = (count_reg == '0) ? ST_NL : ST_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW:
            begin
                out_item.kind       = KIND_GLYPH;
                out_item.pixel_x    = px_full[15:0];
                out_item.pixel_y    = py_full[15:0];
                out_item.byte_value = (ch_reg == CH_BS) ? CH_SPACE : ch_reg;
                out_item.fg_out     = cfg.foreground;
                out_item.bg_out     = cfg.background;
                out_item.last       = 1'b1;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                out_item.kind       = KIND_LINE;
                out_item.byte_value = ram_rdata;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = (idx_reg + CNT_W'(1) == count_reg) ? ST_NL : ST_RD;
                end
            end
            ST_NL:
            begin
                out_item.kind       = KIND_LINE;
                out_item.byte_value = CH_NL;
                out_item.last       = 1'b1;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            code_reg  <= CMD_PRINT;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            code_reg  <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        rem_reg  <= rem_next;
        dcol_reg <= dcol_next;
        drow_reg <= drow_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LINE_DEPTH))
        else $error("line count above store depth");

    a_glyph_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_item.kind == KIND_GLYPH) |-> out_item.last)
        else $error("glyph command not marked last");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NL && out_push) |=> (count_reg == '0))
        else $error("line store not emptied after newline");

    a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (idx_reg < count_reg))
        else $error("flush read beyond stored bytes");

endmodule

FILE: hdl/text_console_cursor_and_line_editor_top.sv
// top level of the text console cursor and line editor
//
// input queue: an item (opcode, char_code) transfers when push is high and
// full is low. opcode print draws one byte on the screen, opcode key edits
// the input line (cr acts as newline, del erases, newline flushes the line).
// result queue: the oldest result sits on result while empty is low and
// transfers when pop is high. glyph commands carry pixel coordinates and
// colors, line bytes carry only the byte; last marks the final result of
// an item. configuration: cfg_index/cfg_data transfer on cfg_valid, cfg_ready
// is always high; write only while the block is idle.
// flow: a two entry command queue decouples the input from the executor
// and a two entry result queue decouples it from the reader. a print or key
// byte goes through fetch, cursor update and glyph multiply, a tab adds
// the column mod tab stop step, a newline key goes through fetch, cursor
// update, a line ram read then transfer per stored byte, and the newline.
// reset clears cursor, line count, queues and loads config defaults; the
// line ram needs no clearing. when the reader stalls the executor waits and
// the command queue fills, then full rises.
module text_console_cursor_and_line_editor_top #(
    parameter int LINE_DEPTH = 32,
    parameter int TAB_STOP   = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tcle_pkg::in_item_t   item,
    output logic                 full,
    output logic                 empty,
    input  logic                 pop,
    output tcle_pkg::out_item_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    import tcle_pkg::*;

    cfg_t                          cfg_reg, cfg_next;
    cmd_item_t                     cmd_item;
    logic                          cmd_empty;
    logic                          cmd_pop;
    logic                          out_push;
    out_item_t                     out_item;
    logic                          out_full;
    logic [$bits(out_item_t)-1:0]  result_bits;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLUMNS:     cfg_next.columns     = cfg_data[COL_W-1:0];
                CFG_CELL_WIDTH:  cfg_next.cell_width  = cfg_data[CELL_W-1:0];
                CFG_CELL_HEIGHT: cfg_next.cell_height = cfg_data[CELL_W-1:0];
                CFG_FOREGROUND:  cfg_next.foreground  = cfg_data;
                CFG_BACKGROUND:  cfg_next.background  = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns     <= RST_COLUMNS;
            cfg_reg.cell_width  <= RST_CELL_WIDTH;
            cfg_reg.cell_height <= RST_CELL_HEIGHT;
            cfg_reg.foreground  <= RST_FOREGROUND;
            cfg_reg.background  <= RST_BACKGROUND;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: classify items into commands
    tcle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd_item  (cmd_item),
        .cmd_empty (cmd_empty)
    );

    // back: cursor, drawing and line store
    tcle_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .TAB_STOP   (TAB_STOP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_item  (cmd_item),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_push  (out_push),
        .out_item  (out_item),
        .out_full  (out_full)
    );

    // result queue toward the reader
    tcle_fifo #(
        .WIDTH ($bits(out_item_t)),
        .DEPTH (2)
    ) u_result_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_item),
        .full  (out_full),
        .pop   (pop),
        .dout  (result_bits),
        .empty (empty)
    );

    assign result = out_item_t'(result_bits);

endmodule
